FILE: design/assert_macros.svh
// Assertion macros shared by the matrix multiply unit.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same, but also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: design/mmu_pkg.sv
// Package for the matrix multiply unit: opcodes, widths and register indexes.
// Depends on nothing; used by the top level, mmu_cell and mmu_chain.
package mmu_pkg;
   localparam int MaxDim    = 8;
   localparam int ElemWidth = 16;
   localparam int ProdWidth = 35;
   localparam int DimWidth  = 4;

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REG_A_ROWS = 2'd0,
      REG_A_COLS = 2'd1,
      REG_B_ROWS = 2'd2,
      REG_B_COLS = 2'd3
   } reg_index_type;

   // Handshake between the sequencer and the cell row for one dot product.
   typedef struct packed {
      logic first;   // first term of a dot product
      logic term;    // a valid term enters the first cell
      logic done;    // the last term entered: capture the sum
   } cell_ctrl_type;
endpackage

FILE: design/matrix_multiply_unit.sv
// Top level of the matrix multiply unit: command channel, APB register file,
// element stores and sequencer. Depends on mmu_pkg, mmu_ram, mmu_chain, assert_macros.svh.
//
// Loads (opcode 0 for A, 1 for B) may be issued back to back. A compute
// beat streams the A-rows by B-columns product row by row; for each element,
// K being A's column count, its K terms enter the cell chain one per cycle
// from the element stores, whose read port gives one operand pair a cycle
// with a registered read; the sum then passes the read register and the last
// cell, and the result beat is shown. Busy is high after the accepting edge
// until the last beat has been shown. When A's column count differs from
// B's row count each element is zero and carries size_mismatch. Results
// are shown for exactly one cycle under rsp_valid and cannot be held off by
// the receiver.
// Out-of-range dimensions are clamped to 1..MAX_DIM; opcode 3 is ignored.
`include "assert_macros.svh"
module matrix_multiply_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_row_index,
   input  logic [2:0]  req_col_index,
   input  logic signed [15:0] req_element_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_out_row,
   output logic [2:0]  rsp_out_col,
   output logic signed [34:0] rsp_product_value,
   output logic        rsp_size_mismatch,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int MAX_DIM = mmu_pkg::MaxDim;
   localparam int IdxW  = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
   localparam int AddrW = 2*IdxW;
   localparam int Depth = MAX_DIM*MAX_DIM;
   localparam int CntW  = $clog2(MAX_DIM+1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_TERM  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // Register file.
   logic [3:0] dim_ff [4];
   logic       wr_cfg;
   assign pready = 1'b1;
   assign wr_cfg = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) dim_ff[i] <= 4'd8;
      end else if (wr_cfg && paddr[1:0] == 2'b00) begin
         dim_ff[paddr[3:2]] <= pwdata[3:0];
      end
   end
   assign prdata = {28'd0, dim_ff[paddr[3:2]]};

   function automatic logic [CntW-1:0] clamp(input logic [3:0] v);
      if (v == 4'd0) return CntW'(1);
      if (32'(v) > MAX_DIM) return CntW'(MAX_DIM);
      return CntW'(v);
   endfunction

   // Dimensions frozen at the start of a compute.
   logic [CntW-1:0] ar_ff, ac_ff, bc_ff;
   logic            mis_ff;
   logic [CntW-1:0] ar_in, ac_in, bc_in;
   logic            mis_in;
   assign ar_in  = clamp(dim_ff[mmu_pkg::REG_A_ROWS]);
   assign ac_in  = clamp(dim_ff[mmu_pkg::REG_A_COLS]);
   assign bc_in  = clamp(dim_ff[mmu_pkg::REG_B_COLS]);
   assign mis_in = clamp(dim_ff[mmu_pkg::REG_A_COLS])
                   != clamp(dim_ff[mmu_pkg::REG_B_ROWS]);

   // Sequencer.
   state_type       state_ff, state_in;
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic            accept;
   logic            load_a, load_b, in_range;
   assign accept   = start && !busy;
   assign in_range = (32'(req_row_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);
   assign load_a   = accept && in_range && req_opcode == mmu_pkg::OP_LOAD_A;
   assign load_b   = accept && in_range && req_opcode == mmu_pkg::OP_LOAD_B;
   assign busy     = state_ff != ST_IDLE;

   logic last_k, last_j, last_i;
   assign last_k = k_ff == ac_ff - CntW'(1);
   assign last_j = j_ff == bc_ff - CntW'(1);
   assign last_i = i_ff == ar_ff - CntW'(1);

   mmu_pkg::cell_ctrl_type ctrl;
   logic term_d_ff, first_d_ff, done_d_ff;   // aligned with registered read
   logic sum_valid;
   logic signed [34:0] sum_value;

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == mmu_pkg::OP_COMPUTE) begin
               i_in = '0;
               j_in = '0;
               k_in = '0;
               state_in = mis_in ? ST_EMIT : ST_TERM;
            end
         end
         ST_TERM: begin
            if (last_k) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + CntW'(1);
            end
         end
         ST_DRAIN: begin
            // Waits for the sum of the last term to leave the chain.
            if (sum_valid) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            k_in = '0;
            if (last_j) begin
               j_in = '0;
               i_in = i_ff + CntW'(1);
            end else begin
               j_in = j_ff + CntW'(1);
            end
            if (last_j && last_i) state_in = ST_IDLE;
            else                  state_in = mis_ff ? ST_EMIT : ST_TERM;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         term_d_ff  <= 1'b0;
         first_d_ff <= 1'b0;
         done_d_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         term_d_ff  <= state_ff == ST_TERM;
         first_d_ff <= state_ff == ST_TERM && k_ff == '0;
         done_d_ff  <= state_ff == ST_TERM && last_k;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      if (state_ff == ST_IDLE) begin
         ar_ff  <= ar_in;
         ac_ff  <= ac_in;
         bc_ff  <= bc_in;
         mis_ff <= mis_in;
      end
   end

   // Stores: A read at (i,k), B at (k,j).
   logic [AddrW-1:0] wr_addr, a_rd_addr, b_rd_addr;
   logic [15:0]      a_rd, b_rd;
   assign wr_addr   = {req_row_index[IdxW-1:0], req_col_index[IdxW-1:0]};
   assign a_rd_addr = {i_ff[IdxW-1:0], k_ff[IdxW-1:0]};
   assign b_rd_addr = {k_ff[IdxW-1:0], j_ff[IdxW-1:0]};

   mmu_ram #(.Width(16), .Depth(Depth)) u_a_ram (
      .clock(clock), .wr_en(load_a), .wr_addr(wr_addr),
      .wr_data(req_element_value), .rd_addr(a_rd_addr), .rd_data(a_rd));
   mmu_ram #(.Width(16), .Depth(Depth)) u_b_ram (
      .clock(clock), .wr_en(load_b), .wr_addr(wr_addr),
      .wr_data(req_element_value), .rd_addr(b_rd_addr), .rd_data(b_rd));

   // The done flag must reach the chain output with the last term's sum, so
   // it is held until the sum is taken.
   logic done_hold_ff;
   always_ff @(posedge clock) begin
      if (reset) done_hold_ff <= 1'b0;
      else if (sum_valid) done_hold_ff <= 1'b0;
      else if (done_d_ff) done_hold_ff <= 1'b1;
   end
   assign ctrl = '{first: first_d_ff, term: term_d_ff, done: done_hold_ff || done_d_ff};

   mmu_chain #(.MaxDim(MAX_DIM)) u_chain (
      .clock(clock), .reset(reset), .ctrl(ctrl), .term_count(ac_ff),
      .a_value(a_rd), .b_value(b_rd),
      .sum_valid(sum_valid), .sum_value(sum_value));

   logic signed [34:0] sum_ff;
   always_ff @(posedge clock) begin
      if (sum_valid) sum_ff <= sum_value;
   end

   // Result beat.
   assign rsp_valid         = state_ff == ST_EMIT;
   assign rsp_out_row       = i_ff[2:0];
   assign rsp_out_col       = j_ff[2:0];
   assign rsp_product_value = mis_ff ? '0 : sum_ff;
   assign rsp_size_mismatch = mis_ff;
   assign rsp_last          = last_i && last_j;

   `ASSERT_CLK(a_no_beat_idle, clock, reset, (rsp_valid |-> busy), "result beat while idle")
   `ASSERT_CLK(a_last_ends, clock, reset, (rsp_valid && rsp_last |=> !busy), "busy after last beat")
   `ASSERT_CLK(a_onehot, clock, reset, ($onehot(state_ff)), "state not one-hot")
   `ASSERT_ALWAYS(a_pready, clock, (pready), "pready low")
endmodule

FILE: design/mmu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module mmu_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/mmu_cell.sv
// One multiply-accumulate cell of the chain: multiplies a term, adds it to the
// partial sum handed in by its neighbour and passes it on. Depends on mmu_pkg.
module mmu_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic                                 in_first,
   input  logic signed [mmu_pkg::ElemWidth-1:0] in_a,
   input  logic signed [mmu_pkg::ElemWidth-1:0] in_b,
   input  logic signed [mmu_pkg::ProdWidth-1:0] in_sum,
   output logic                                 out_valid,
   output logic signed [mmu_pkg::ProdWidth-1:0] out_sum
);
   logic signed [2*mmu_pkg::ElemWidth-1:0] mult;
   logic signed [mmu_pkg::ProdWidth-1:0]   sum_in;
   logic signed [mmu_pkg::ProdWidth-1:0]   sum_ff;
   logic                                   valid_in;
   logic                                   valid_ff;

   assign mult     = in_a * in_b;
   assign valid_in = in_valid;
   // The first term of a dot product starts from zero.
   assign sum_in   = (in_first ? '0 : in_sum)
                     + mmu_pkg::ProdWidth'(mult);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_sum   = sum_ff;
endmodule

FILE: design/mmu_chain.sv
// Row of MAX_DIM cells: term k of a dot product is taken by cell k, one
// cell per cycle, the partial sum travelling along. Depends on mmu_pkg, mmu_cell.
module mmu_chain #(
   parameter int MaxDim = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mmu_pkg::cell_ctrl_type               ctrl,
   input  logic [$clog2(MaxDim+1)-1:0]          term_count,
   input  logic signed [mmu_pkg::ElemWidth-1:0] a_value,
   input  logic signed [mmu_pkg::ElemWidth-1:0] b_value,
   output logic                                 sum_valid,
   output logic signed [mmu_pkg::ProdWidth-1:0] sum_value
);
   localparam int CntW = $clog2(MaxDim+1);
   logic                                 valid_w [MaxDim+1];
   logic signed [mmu_pkg::ProdWidth-1:0] sum_w   [MaxDim+1];

   assign valid_w[0] = ctrl.term;
   assign sum_w[0]   = '0;

   // Each cell sees the operands of its own cycle; the partial sum marches on
   // so cell k adds term k to the sum of terms 0..k-1.
   for (genvar k = 0; k < MaxDim; k++) begin : g_cell
      mmu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[k]),
         .in_first  (k == 0),
         .in_a      (a_value),
         .in_b      (b_value),
         .in_sum    (sum_w[k]),
         .out_valid (valid_w[k+1]),
         .out_sum   (sum_w[k+1])
      );
   end

   always_comb begin
      sum_valid = 1'b0;
      sum_value = '0;
      for (int k = 1; k <= MaxDim; k++) begin
         if (term_count == CntW'(k)) begin
            sum_valid = valid_w[k] && ctrl.done;
            sum_value = sum_w[k];
         end
      end
   end
endmodule
